// ===== rtl/tepa_pkg.sv =====
package tepa_pkg;

    // Fixed field widths of the request and response transfers
    localparam int PAGE_CNT_W  = 11;
    localparam int TAG_FIELD_W = 16;
    localparam int BASE_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PAGES  = 1024;
    localparam int DEF_PAGE_WORDS = 64;
    localparam int DEF_TAG_BITS   = 16;

    // Register index (paddr word bit)
    localparam logic REG_POOL_PAGES = 1'b0;

    // Request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_BAD_TAG = 2'd2
    } status_t;

    typedef struct packed {
        logic                   is_free;
        logic [PAGE_CNT_W-1:0]  pages;
        logic                   at_head;
        logic [TAG_FIELD_W-1:0] tag;
    } req_t;

    typedef struct packed {
        logic                  load;
        logic [PAGE_CNT_W-1:0] load_pages;
        logic [PAGE_CNT_W-1:0] pages;
    } cfg_t;

endpackage

// ===== rtl/tepa_front.sv =====
module tepa_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [tepa_pkg::PAGE_CNT_W-1:0]      page_count,
    input  logic                                 at_head,
    input  logic [tepa_pkg::TAG_FIELD_W-1:0]     client_tag,
    output tepa_pkg::req_t                       head_item,
    output logic                                 head_valid,
    input  logic                                 pop
);
    import tepa_pkg::*;

    req_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;
    req_t       in_item;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign do_pop     = pop && head_valid;
    assign head_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.is_free = (action == ACT_FREE);
        in_item.pages   = page_count;
        in_item.at_head = at_head;
        in_item.tag     = client_tag;
        wr_ptr_next     = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next     = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next      = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tepa_back.sv =====
module tepa_back #(
    parameter int MAX_PAGES  = tepa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_WORDS = tepa_pkg::DEF_PAGE_WORDS,
    parameter int TAG_BITS   = tepa_pkg::DEF_TAG_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tepa_pkg::cfg_t                       cfg,
    input  tepa_pkg::req_t                       head_item,
    input  logic                                 head_valid,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tepa_pkg::TAG_FIELD_W-1:0]     echo_tag,
    output logic [tepa_pkg::STATUS_W-1:0]        status,
    output logic [tepa_pkg::BASE_W-1:0]          base_address
);
    import tepa_pkg::*;

    localparam int PTR_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int AW    = ((CNT_W > PAGE_CNT_W) ? CNT_W : PAGE_CNT_W) + 1;
    localparam int TW    = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
    localparam int PW    = ((PTR_W + 13) > BASE_W) ? (PTR_W + 13) : BASE_W;
    localparam int POOL_RESET_I = (MAX_PAGES < 1024) ? MAX_PAGES : 1024;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;
    req_t                 cur_reg;
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     tail_reg;
    logic [PTR_W-1:0]     oldest_reg;
    logic [PTR_W-1:0]     next_slot_reg;
    logic [CNT_W-1:0]     free_reg;
    logic [CNT_W-1:0]     live_reg;

    logic [PTR_W-1:0]     head_next;
    logic [PTR_W-1:0]     tail_next;
    logic [PTR_W-1:0]     oldest_next;
    logic [PTR_W-1:0]     next_slot_next;
    logic [CNT_W-1:0]     free_next;
    logic [CNT_W-1:0]     live_next;

    logic [TW-1:0]        tag_mem [MAX_PAGES];
    logic [TW-1:0]        rd_old_reg;
    logic [TW-1:0]        rd_new_reg;
    logic [PTR_W-1:0]     rd_new_addr;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;

    logic                 out_valid_reg;
    logic [TAG_FIELD_W-1:0] echo_tag_reg;
    status_t              status_reg;
    logic [BASE_W-1:0]    base_reg;
    status_t              status_next;
    logic [BASE_W-1:0]    base_next;

    logic                 commit;
    logic [AW-1:0]        pool_w;
    logic [AW-1:0]        n_w;
    logic [AW-1:0]        n_mod;
    logic [AW-1:0]        free_w;
    logic [AW-1:0]        live_w;
    logic [AW-1:0]        used_w;
    logic [AW-1:0]        head_sub;
    logic [AW-1:0]        head_add;
    logic [AW-1:0]        tail_sub;
    logic [AW-1:0]        tail_add;
    logic [AW-1:0]        oldest_dec;
    logic [AW-1:0]        oldest_inc;
    logic [AW-1:0]        next_dec;
    logic [AW-1:0]        next_inc;
    logic                 alloc_ok;
    logic                 free_ok;
    logic                 old_hit;
    logic                 new_hit;
    logic [TW-1:0]        tag_c;
    logic [PW-1:0]        base_prod;

    assign pop          = (state_reg == S_IDLE) && head_valid;
    assign commit       = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid    = out_valid_reg;
    assign echo_tag     = echo_tag_reg;
    assign status       = status_reg;
    assign base_address = base_reg;

    // Ring arithmetic: pointers stay below the pool size and a successful request
    // never moves more pages than the pool holds, so one compare-and-subtract wraps.
    always_comb
    begin
        pool_w = AW'(cfg.pages);
        n_w    = AW'(cur_reg.pages);
        n_mod  = (n_w == pool_w) ? '0 : n_w;
        free_w = AW'(free_reg);
        live_w = AW'(live_reg);
        used_w = (free_w <= pool_w) ? (pool_w - free_w) : '0;

        head_sub = AW'(head_reg) + pool_w - n_mod;
        if (head_sub >= pool_w)
        begin
            head_sub = head_sub - pool_w;
        end
        head_add = AW'(head_reg) + n_mod;
        if (head_add >= pool_w)
        begin
            head_add = head_add - pool_w;
        end
        tail_sub = AW'(tail_reg) + pool_w - n_mod;
        if (tail_sub >= pool_w)
        begin
            tail_sub = tail_sub - pool_w;
        end
        tail_add = AW'(tail_reg) + n_mod;
        if (tail_add >= pool_w)
        begin
            tail_add = tail_add - pool_w;
        end

        oldest_dec = (oldest_reg == '0) ? (pool_w - AW'(1)) : (AW'(oldest_reg) - AW'(1));
        oldest_inc = AW'(oldest_reg) + AW'(1);
        if (oldest_inc == pool_w)
        begin
            oldest_inc = '0;
        end
        next_dec = (next_slot_reg == '0) ? (pool_w - AW'(1))
                                         : (AW'(next_slot_reg) - AW'(1));
        next_inc = AW'(next_slot_reg) + AW'(1);
        if (next_inc == pool_w)
        begin
            next_inc = '0;
        end
        rd_new_addr = next_dec[PTR_W-1:0];

        tag_c    = cur_reg.tag[TW-1:0];
        alloc_ok = (free_w >= n_w) && (live_w < pool_w);
        free_ok  = (live_reg != '0) && (used_w >= n_w);
        old_hit  = (rd_old_reg == tag_c);
        new_hit  = (rd_new_reg == tag_c);

        head_next      = head_reg;
        tail_next      = tail_reg;
        oldest_next    = oldest_reg;
        next_slot_next = next_slot_reg;
        free_next      = free_reg;
        live_next      = live_reg;
        mem_we         = 1'b0;
        mem_waddr      = next_slot_reg;
        status_next    = ST_NO_ROOM;
        base_prod      = '0;

        if (!cur_reg.is_free)
        begin
            if (alloc_ok)
            begin
                if (cur_reg.at_head)
                begin
                    head_next   = head_sub[PTR_W-1:0];
                    oldest_next = oldest_dec[PTR_W-1:0];
                    mem_waddr   = oldest_dec[PTR_W-1:0];
                    base_prod   = PW'(head_sub[PTR_W-1:0]) * PW'(PAGE_WORDS);
                end
                else
                begin
                    tail_next      = tail_add[PTR_W-1:0];
                    next_slot_next = next_inc[PTR_W-1:0];
                    base_prod      = PW'(tail_reg) * PW'(PAGE_WORDS);
                end
                mem_we      = 1'b1;
                free_next   = free_reg - CNT_W'(cur_reg.pages);
                live_next   = live_reg + CNT_W'(1);
                status_next = ST_OK;
            end
        end
        else if (free_ok)
        begin
            if (old_hit)
            begin
                oldest_next = oldest_inc[PTR_W-1:0];
                head_next   = head_add[PTR_W-1:0];
                free_next   = free_reg + CNT_W'(cur_reg.pages);
                live_next   = live_reg - CNT_W'(1);
                status_next = ST_OK;
            end
            else if (new_hit)
            begin
                next_slot_next = next_dec[PTR_W-1:0];
                tail_next      = tail_sub[PTR_W-1:0];
                free_next      = free_reg + CNT_W'(cur_reg.pages);
                live_next      = live_reg - CNT_W'(1);
                status_next    = ST_OK;
            end
            else
            begin
                status_next = ST_BAD_TAG;
            end
        end
        base_next = base_prod[BASE_W-1:0];
    end

    // Tag ring: both ends read on issue, one tag written when an allocate commits
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_old_reg <= tag_mem[oldest_reg];
            rd_new_reg <= tag_mem[rd_new_addr];
        end
        if (commit && mem_we)
        begin
            tag_mem[mem_waddr] <= tag_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            echo_tag_reg  <= '0;
            status_reg    <= ST_OK;
            base_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            oldest_reg    <= '0;
            next_slot_reg <= '0;
            free_reg      <= CNT_W'(POOL_RESET_I);
            live_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= commit || (out_valid_reg && out_stall);
            if (commit)
            begin
                echo_tag_reg <= cur_reg.tag;
                status_reg   <= status_next;
                base_reg     <= base_next;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg.load)
            begin
                head_reg      <= '0;
                tail_reg      <= '0;
                oldest_reg    <= '0;
                next_slot_reg <= '0;
                free_reg      <= CNT_W'(cfg.load_pages);
                live_reg      <= '0;
            end
            else if (commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                oldest_reg    <= oldest_next;
                next_slot_reg <= next_slot_next;
                free_reg      <= free_next;
                live_reg      <= live_next;
            end
        end
    end

    // during a pool write the new size is already on cfg.pages, the counters not yet
    a_free_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.load |-> (AW'(free_reg) <= AW'(cfg.pages)))
        else $error("free page count exceeds pool size");

    a_live_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.load |-> (AW'(live_reg) <= AW'(cfg.pages)))
        else $error("live allocation count exceeds pool size");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.load |-> ((AW'(head_reg) < AW'(cfg.pages)) && (AW'(tail_reg) < AW'(cfg.pages))))
        else $error("page pointer outside the ring");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("committed request not presented");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> !pop)
        else $error("queue popped while a request is in execution");

endmodule

// ===== rtl/two_ended_page_allocator_core.sv =====
// Two-ended page allocator: a ring of pool_pages pages handed out like a deque.
// Allocate transfers take pages at the head (below the head pointer) or at the
// tail and return the region's word address; free transfers give pages back and
// succeed only for the oldest or newest live tag. The back end reads both ends of
// the tag ring, then commits (writing the tag back on an allocate) and takes a new
// request only after the last one has committed; a 2-entry request queue and
// a response register decouple both channels. Writing pool_pages (byte address
// 0) reinitialises the ring; write it only while no request is outstanding. The
// tag memory needs no clearing pass after reset.
module two_ended_page_allocator_core #(
    parameter int MAX_PAGES  = tepa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_WORDS = tepa_pkg::DEF_PAGE_WORDS,
    parameter int TAG_BITS   = tepa_pkg::DEF_TAG_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tepa_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tepa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tepa_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [tepa_pkg::PAGE_CNT_W-1:0]      page_count,
    input  logic                                 at_head,
    input  logic [tepa_pkg::TAG_FIELD_W-1:0]     client_tag,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tepa_pkg::TAG_FIELD_W-1:0]     echo_tag,
    output logic [tepa_pkg::STATUS_W-1:0]        status,
    output logic [tepa_pkg::BASE_W-1:0]          base_address
);
    import tepa_pkg::*;

    localparam int POOL_RESET_I = (MAX_PAGES < 1024) ? MAX_PAGES : 1024;
    localparam logic [PAGE_CNT_W-1:0] POOL_RESET = PAGE_CNT_W'(POOL_RESET_I);

    logic [PAGE_CNT_W-1:0] pool_reg;
    logic [PAGE_CNT_W-1:0] pool_next;
    logic                  cfg_wr;
    cfg_t                  cfg;
    req_t                  head_item;
    logic                  head_valid;
    logic                  pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_PAGES);
    assign prdata = (paddr[2] == REG_POOL_PAGES) ? APB_DATA_W'(pool_reg) : '0;

    // Saturate the low PAGE_CNT_W bits of the written size into 1..MAX_PAGES
    always_comb
    begin
        pool_next = pwdata[PAGE_CNT_W-1:0];
        if (pool_next == '0)
        begin
            pool_next = PAGE_CNT_W'(1);
        end
        else if (32'(pool_next) > MAX_PAGES)
        begin
            pool_next = PAGE_CNT_W'(MAX_PAGES);
        end
        cfg.load       = cfg_wr;
        cfg.load_pages = pool_next;
        cfg.pages      = cfg_wr ? pool_next : pool_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_RESET;
        end
        else if (cfg_wr)
        begin
            pool_reg <= pool_next;
        end
    end

    tepa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .page_count  (page_count),
        .at_head     (at_head),
        .client_tag  (client_tag),
        .head_item   (head_item),
        .head_valid  (head_valid),
        .pop         (pop)
    );

    tepa_back #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_WORDS (PAGE_WORDS),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_item    (head_item),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .echo_tag     (echo_tag),
        .status       (status),
        .base_address (base_address)
    );

endmodule
